FILE: rtl/core/stochastic_symbol_rewriter_assert.svh
// ============================================================================
// Stochastic symbol rewriter assertion macros
// Concurrent assertion helpers that compile away when NO_ASSERTIONS is set.
// ============================================================================
`ifndef STOCHASTIC_SYMBOL_REWRITER_ASSERT_SVH
`define STOCHASTIC_SYMBOL_REWRITER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checks a property on every rising clock edge outside of reset.
`define SSR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("stochastic_symbol_rewriter: assertion failed");

// Checks that a condition in one cycle implies a condition in the next cycle.
`define SSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("stochastic_symbol_rewriter: assertion failed");

`else

`define SSR_ASSERT(lbl, clk, rstn, prop)
`define SSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/core/ssr_pkg.sv
// ============================================================================
// Stochastic symbol rewriter package
// Shared constants, request and result types, and controller interface types.
// ============================================================================
package ssr_pkg;

  localparam int unsigned MAX_VARIATIONS = 64;
  localparam int unsigned MAX_RHS        = 32;

  localparam int unsigned SYM_W = 8;
  localparam int unsigned BND_W = 7;

  // Bounds are cumulative percentages; larger values saturate here.
  localparam logic [BND_W-1:0] BOUND_MAX = 7'd100;

  typedef enum logic [1:0] {
    OP_REWRITE = 2'd0,
    OP_BEGIN   = 2'd1,
    OP_APPEND  = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK          = 2'd0,
    STS_NO_COVER    = 2'd1,
    STS_TABLE_FULL  = 2'd2,
    STS_STRING_FULL = 2'd3
  } status_e;

  // Kind of a result that stands alone (one result, marked last).
  typedef enum logic [2:0] {
    RES_ACK      = 3'd0,
    RES_ECHO     = 3'd1,
    RES_NOCOVER  = 3'd2,
    RES_EMPTY    = 3'd3,
    RES_TAB_FULL = 3'd4,
    RES_STR_FULL = 3'd5
  } res_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [SYM_W-1:0] symbol;
    logic [BND_W-1:0] bound;
    logic [BND_W-1:0] draw;
    logic [SYM_W-1:0] rhs_char;
  } in_req_t;

  typedef struct packed {
    logic [SYM_W-1:0] out_symbol;
    logic             out_valid;
    logic             last;
    logic [1:0]       status;
  } out_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic begin_var;
    logic append;
    logic capture;
    logic scan_run;
    logic len_rd;
    logic emit_start;
    logic emit_run;
    logic res_load;
    res_e res_kind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic table_full;
    logic table_empty;
    logic string_full;
    logic scan_done;
    logic matched;
    logic hit;
    logic len_zero;
    logic emit_done;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/ssr_ram.sv
// ============================================================================
// Stochastic symbol rewriter generic RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ============================================================================
module ssr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ssr_ctrl.sv
// ============================================================================
// Stochastic symbol rewriter controller
// Sequences loads, the rule scan, the length fetch and the symbol emission.
// ============================================================================
module ssr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    op_i,
  output logic          in_stall_o,
  input  ssr_pkg::sts_t sts_i,
  output ssr_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_LEN_RD  = 6'b000100,
    S_LEN_CHK = 6'b001000,
    S_EMIT    = 6'b010000,
    S_SINGLE  = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  ssr_pkg::res_e   kind_q, kind_d;
  logic            accept;

  assign in_stall_o = !((state_q == S_IDLE) && sts_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    cmd_o.res_kind = ssr_pkg::RES_ACK;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (ssr_pkg::op_e'(op_i))
            ssr_pkg::OP_CLEAR: begin
              cmd_o.clear    = 1'b1;
              cmd_o.res_load = 1'b1;
            end
            ssr_pkg::OP_BEGIN: begin
              cmd_o.res_load = 1'b1;
              if (sts_i.table_full) begin
                cmd_o.res_kind = ssr_pkg::RES_TAB_FULL;
              end else begin
                cmd_o.begin_var = 1'b1;
              end
            end
            ssr_pkg::OP_APPEND: begin
              cmd_o.res_load = 1'b1;
              if (sts_i.table_empty) begin
                cmd_o.res_kind = ssr_pkg::RES_ACK;
              end else if (sts_i.string_full) begin
                cmd_o.res_kind = ssr_pkg::RES_STR_FULL;
              end else begin
                cmd_o.append = 1'b1;
              end
            end
            ssr_pkg::OP_REWRITE: begin
              cmd_o.capture = 1'b1;
              state_d       = S_SCAN;
            end
            default: begin
              cmd_o.res_load = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_done) begin
          if (!sts_i.matched) begin
            kind_d  = ssr_pkg::RES_ECHO;
            state_d = S_SINGLE;
          end else if (!sts_i.hit) begin
            kind_d  = ssr_pkg::RES_NOCOVER;
            state_d = S_SINGLE;
          end else begin
            state_d = S_LEN_RD;
          end
        end
      end
      S_LEN_RD: begin
        cmd_o.len_rd = 1'b1;
        state_d      = S_LEN_CHK;
      end
      S_LEN_CHK: begin
        if (sts_i.len_zero) begin
          kind_d  = ssr_pkg::RES_EMPTY;
          state_d = S_SINGLE;
        end else begin
          cmd_o.emit_start = 1'b1;
          state_d          = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.emit_run = 1'b1;
        if (sts_i.emit_done) begin
          state_d = S_IDLE;
        end
      end
      S_SINGLE: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = kind_q;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= ssr_pkg::RES_ACK;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

FILE: rtl/core/ssr_dp.sv
// ============================================================================
// Stochastic symbol rewriter datapath
// Rule memories, table counters, scan pipeline, emission queue and output register.
// ============================================================================
module ssr_dp #(
  parameter int unsigned MaxVariations = ssr_pkg::MAX_VARIATIONS,
  parameter int unsigned MaxRhs        = ssr_pkg::MAX_RHS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssr_pkg::in_req_t  in_req_i,
  input  ssr_pkg::cmd_t     cmd_i,
  output ssr_pkg::sts_t     sts_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output ssr_pkg::out_res_t out_res_o
);

  localparam int unsigned CW    = $clog2(MaxVariations + 1);
  localparam int unsigned IW    = (MaxVariations > 1) ? $clog2(MaxVariations) : 1;
  localparam int unsigned LW    = $clog2(MaxRhs + 1);
  localparam int unsigned RD    = MaxVariations * MaxRhs;
  localparam int unsigned RW    = (RD > 1) ? $clog2(RD) : 1;
  localparam int unsigned SYM_W = ssr_pkg::SYM_W;
  localparam int unsigned BND_W = ssr_pkg::BND_W;
  localparam int unsigned VT_W  = SYM_W + BND_W;

  // Table fill state.
  logic [CW-1:0] count_q, count_d;
  logic [LW-1:0] cur_len_q, cur_len_d;
  logic [IW-1:0] newest_idx;

  // Scan pipeline.
  logic [CW-1:0]    issue_q, issue_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IW-1:0]    cmp_idx_q, cmp_idx_d;
  logic             matched_q, matched_d;
  logic             hit_q, hit_d;
  logic [IW-1:0]    sel_idx_q, sel_idx_d;
  logic [SYM_W-1:0] req_sym_q, req_sym_d;
  logic [BND_W-1:0] req_draw_q, req_draw_d;
  logic             scan_issue;

  // Emission.
  logic [LW-1:0] len_q, len_d;
  logic [RW-1:0] base_q, base_d;
  logic [LW-1:0] k_q, k_d;
  logic          pend_q, pend_d;
  logic          pend_last_q, pend_last_d;
  logic          emit_issue;
  logic          consume;

  // Output register.
  ssr_pkg::out_res_t out_q, out_d;
  logic              out_vld_q, out_vld_d;
  logic              out_free;
  ssr_pkg::out_res_t single_res;

  // Memory ports.
  logic [VT_W-1:0]  vt_wdata, vt_rdata;
  logic [BND_W-1:0] bnd_sat;
  logic             vl_we;
  logic [IW-1:0]    vl_waddr;
  logic [LW-1:0]    vl_wdata, vl_rdata;
  logic [RW-1:0]    rhs_waddr, rhs_raddr;
  logic [SYM_W-1:0] rhs_rdata;

  assign newest_idx = IW'(count_q - CW'(1));
  assign bnd_sat    = (in_req_i.bound > ssr_pkg::BOUND_MAX) ? ssr_pkg::BOUND_MAX
                                                            : in_req_i.bound;
  assign vt_wdata   = {in_req_i.symbol, bnd_sat};

  assign vl_we    = cmd_i.begin_var || cmd_i.append;
  assign vl_waddr = cmd_i.begin_var ? count_q[IW-1:0] : newest_idx;
  assign vl_wdata = cmd_i.begin_var ? '0 : LW'(cur_len_q + LW'(1));

  assign rhs_waddr = RW'(RW'(newest_idx) * RW'(MaxRhs)) + RW'(cur_len_q);
  assign rhs_raddr = base_q + RW'(k_q);

  ssr_ram #(
    .Width (VT_W),
    .Depth (MaxVariations)
  ) u_vtab (
    .clk_i   (clk_i),
    .we_i    (cmd_i.begin_var),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (vt_wdata),
    .re_i    (scan_issue),
    .raddr_i (issue_q[IW-1:0]),
    .rdata_o (vt_rdata)
  );

  ssr_ram #(
    .Width (LW),
    .Depth (MaxVariations)
  ) u_vlen (
    .clk_i   (clk_i),
    .we_i    (vl_we),
    .waddr_i (vl_waddr),
    .wdata_i (vl_wdata),
    .re_i    (cmd_i.len_rd),
    .raddr_i (sel_idx_q),
    .rdata_o (vl_rdata)
  );

  ssr_ram #(
    .Width (SYM_W),
    .Depth (RD)
  ) u_rhs (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i (rhs_waddr),
    .wdata_i (in_req_i.rhs_char),
    .re_i    (emit_issue),
    .raddr_i (rhs_raddr),
    .rdata_o (rhs_rdata)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign scan_issue = cmd_i.scan_run && !hit_q && (issue_q < count_q);
  assign consume    = cmd_i.emit_run && pend_q && out_free;
  assign emit_issue = cmd_i.emit_run && (k_q < len_q) && (!pend_q || consume);

  always_comb begin
    count_d    = count_q;
    cur_len_d  = cur_len_q;
    issue_d    = issue_q;
    cmp_vld_d  = cmp_vld_q;
    cmp_idx_d  = cmp_idx_q;
    matched_d  = matched_q;
    hit_d      = hit_q;
    sel_idx_d  = sel_idx_q;
    req_sym_d  = req_sym_q;
    req_draw_d = req_draw_q;

    if (cmd_i.clear) begin
      count_d = '0;
    end
    if (cmd_i.begin_var) begin
      count_d   = CW'(count_q + CW'(1));
      cur_len_d = '0;
    end
    if (cmd_i.append) begin
      cur_len_d = LW'(cur_len_q + LW'(1));
    end

    if (cmd_i.capture) begin
      issue_d    = '0;
      cmp_vld_d  = 1'b0;
      matched_d  = 1'b0;
      hit_d      = 1'b0;
      req_sym_d  = in_req_i.symbol;
      req_draw_d = in_req_i.draw;
    end else if (cmd_i.scan_run) begin
      issue_d   = scan_issue ? CW'(issue_q + CW'(1)) : issue_q;
      cmp_vld_d = scan_issue;
      cmp_idx_d = issue_q[IW-1:0];
      // Compare stage: data read in the previous cycle.
      if (cmp_vld_q && !hit_q && (vt_rdata[VT_W-1:BND_W] == req_sym_q)) begin
        matched_d = 1'b1;
        if (vt_rdata[BND_W-1:0] >= req_draw_q) begin
          hit_d     = 1'b1;
          sel_idx_d = cmp_idx_q;
        end
      end
    end
  end

  always_comb begin
    len_d       = len_q;
    base_d      = base_q;
    k_d         = k_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    if (cmd_i.emit_start) begin
      len_d  = vl_rdata;
      base_d = RW'(RW'(sel_idx_q) * RW'(MaxRhs));
      k_d    = '0;
      pend_d = 1'b0;
    end else begin
      if (emit_issue) begin
        k_d         = LW'(k_q + LW'(1));
        pend_d      = 1'b1;
        pend_last_d = (LW'(k_q + LW'(1)) == len_q);
      end else if (consume) begin
        pend_d = 1'b0;
      end
    end
  end

  always_comb begin
    single_res            = '0;
    single_res.last       = 1'b1;
    single_res.status     = ssr_pkg::STS_OK;
    case (cmd_i.res_kind)
      ssr_pkg::RES_ECHO: begin
        single_res.out_symbol = req_sym_q;
        single_res.out_valid  = 1'b1;
      end
      ssr_pkg::RES_NOCOVER:  single_res.status = ssr_pkg::STS_NO_COVER;
      ssr_pkg::RES_TAB_FULL: single_res.status = ssr_pkg::STS_TABLE_FULL;
      ssr_pkg::RES_STR_FULL: single_res.status = ssr_pkg::STS_STRING_FULL;
      default:               single_res.status = ssr_pkg::STS_OK;
    endcase
  end

  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q;
    if (cmd_i.res_load) begin
      out_d     = single_res;
      out_vld_d = 1'b1;
    end else if (consume) begin
      out_d.out_symbol = rhs_rdata;
      out_d.out_valid  = 1'b1;
      out_d.last       = pend_last_q;
      out_d.status     = ssr_pkg::STS_OK;
      out_vld_d        = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      cur_len_q <= '0;
      issue_q   <= '0;
      cmp_vld_q <= 1'b0;
      matched_q <= 1'b0;
      hit_q     <= 1'b0;
      k_q       <= '0;
      len_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      cur_len_q <= cur_len_d;
      issue_q   <= issue_d;
      cmp_vld_q <= cmp_vld_d;
      matched_q <= matched_d;
      hit_q     <= hit_d;
      k_q       <= k_d;
      len_q     <= len_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cmp_idx_d;
    sel_idx_q   <= sel_idx_d;
    req_sym_q   <= req_sym_d;
    req_draw_q  <= req_draw_d;
    base_q      <= base_d;
    pend_last_q <= pend_last_d;
    out_q       <= out_d;
  end

  assign sts_o.table_full  = (count_q >= CW'(MaxVariations));
  assign sts_o.table_empty = (count_q == '0);
  assign sts_o.string_full = (cur_len_q >= LW'(MaxRhs));
  assign sts_o.scan_done   = hit_q || (!cmp_vld_q && (issue_q >= count_q));
  assign sts_o.matched     = matched_q;
  assign sts_o.hit         = hit_q;
  assign sts_o.len_zero    = (vl_rdata == '0);
  assign sts_o.emit_done   = consume && pend_last_q;
  assign sts_o.out_free    = out_free;

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

endmodule

FILE: rtl/core/stochastic_symbol_rewriter.sv
// ============================================================================
// Stochastic symbol rewriter
// Rule table of stochastic production variations with load and rewrite requests.
// ============================================================================
//
//   Channel  Direction  Handshake                 Payload
//   -------  ---------  ------------------------  ------------------------------
//   in       input      in_valid_i / in_stall_o   in_req_i  (ssr_pkg::in_req_t)
//   out      output     out_valid_o / out_stall_i out_res_o (ssr_pkg::out_res_t)
//
// A load request (clear, begin, append) gives one result.
// A rewrite request holds the block while the scan reads the variations, one
// per cycle from the variation memory up to the first covering variation or the
// end of the table, and while the right side streams out, one symbol per cycle
// from the right-side memory while the output does not stall. An echo, an
// uncovered draw or an empty right side gives a single result instead.
// Reset clears the control state and empties the table.
// A stalled output holds its result; the emission pauses until the slot frees.
//
// Requests are taken one at a time. The controller accepts a new request only
// in its idle state and only while the output register can take a result, so
// a load request writes the table and places its result in the same cycle.
// A rewrite first walks the table in insertion order through a two-stage scan
// (memory read, then compare), remembering whether any variation of the symbol
// exists and where the first covering one sits. The chosen variation's length
// is then read, and the right side streams out through a one-entry queue held
// in the memory's read register in front of the output register.
//
// The memories hold no reset values: only entries below the variation count,
// and right-side entries below a variation's length, are ever read.
//
`include "stochastic_symbol_rewriter_assert.svh"

module stochastic_symbol_rewriter #(
  parameter int unsigned MaxVariations = ssr_pkg::MAX_VARIATIONS,
  parameter int unsigned MaxRhs        = ssr_pkg::MAX_RHS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ssr_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ssr_pkg::out_res_t out_res_o
);

  // Command and status groups between the controller and the datapath.
  ssr_pkg::cmd_t cmd;
  ssr_pkg::sts_t sts;

  ssr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (in_req_i.operation),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ssr_dp #(
    .MaxVariations (MaxVariations),
    .MaxRhs        (MaxRhs)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o)
  );

  // The output register is only loaded when it is empty or being drained.
  `SSR_ASSERT(a_load_into_free_slot, clk_i, rst_ni, !cmd.res_load || sts.out_free)

  // Emission only ever starts after the scan found a covering variation.
  `SSR_ASSERT(a_emit_after_hit, clk_i, rst_ni, !cmd.emit_start || sts.hit)

  // An accepted rewrite keeps the input stalled while its scan runs.
  `SSR_ASSERT_NEXT(a_rewrite_blocks_input, clk_i, rst_ni,
    in_valid_i && !in_stall_o && (in_req_i.operation == ssr_pkg::OP_REWRITE),
    in_stall_o)

endmodule
